>>> rtl/tmbls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmbls_pkg: shared types and constants for the timed motor bank
// Widths of the command and result fields, command codes and the
// per-channel status carried from the lanes to the merge stage.
// ----------------------------------------------------------------------------
package tmbls_pkg;

  // Default channel count and its legal range upper bound
  localparam int MOTORS_DEFAULT = 14;

  // Fixed field widths
  localparam int FIELD_BITS = 14;   // switch, pin and running masks
  localparam int IDX_W      = 4;    // motor_index
  localparam int COUNT_W    = 32;   // run_ticks and per-channel countdown

  // Packed slave-side tdata: switch_levels, motor_index, run_ticks, reverse_dir
  localparam int IN_BITS    = FIELD_BITS + IDX_W + COUNT_W + 1;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int SW_LSB     = 0;
  localparam int IDX_LSB    = SW_LSB + FIELD_BITS;
  localparam int TICKS_LSB  = IDX_LSB + IDX_W;
  localparam int REV_LSB    = TICKS_LSB + COUNT_W;

  // Packed master-side tdata: in1_levels, in2_levels, running_mask
  localparam int OUT_BITS   = 3 * FIELD_BITS;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Command kinds carried in tuser
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  // Beat-level command broadcast to every lane
  typedef struct packed {
    logic               tick;    // accepted tick beat
    logic               start;   // accepted start beat
    logic               dir;     // reverse_dir of a start
    logic [COUNT_W-1:0] ticks;   // run_ticks of a start
  } lane_cmd_t;

  // Per-channel state after the beat
  typedef struct packed {
    logic run;
    logic dir;
  } lane_status_t;

endpackage : tmbls_pkg
`default_nettype wire

>>> rtl/tmbls_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmbls_lane: one motor channel
// Holds the run countdown, direction and last switch level of one channel,
// applies a tick or a start beat, and reports its state after the beat.
// ----------------------------------------------------------------------------
module tmbls_lane (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tmbls_pkg::lane_cmd_t  cmd,
  input  wire logic                  sel,       // start addresses this channel
  input  wire logic                  sw_level,  // limit switch, 0 = pressed
  output tmbls_pkg::lane_status_t    status
);
  import tmbls_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               dir;
  logic               dir_next;
  logic               last_sw;
  logic               last_sw_next;

  // Work out the channel state after this beat
  always_comb begin
    count_next   = count;
    dir_next     = dir;
    last_sw_next = last_sw;
    if (cmd.tick) begin
      if (!sw_level && last_sw && (count != '0)) begin
        count_next = '0;
      end else if (count == COUNT_W'(1)) begin
        count_next = '0;
      end else if (count != '0) begin
        count_next = count - COUNT_W'(1);
      end
      last_sw_next = sw_level;
    end else if (cmd.start && sel && (cmd.ticks != '0)) begin
      count_next = cmd.ticks;
      dir_next   = cmd.dir;
    end
  end

  // Hold the channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dir     <= 1'b0;
      last_sw <= 1'b1;
    end else begin
      count   <= count_next;
      dir     <= dir_next;
      last_sw <= last_sw_next;
    end
  end

  assign status.run = (count_next != '0);
  assign status.dir = dir_next;

endmodule : tmbls_lane
`default_nettype wire

>>> rtl/tmbls_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmbls_merge: combine lane states into one result beat
// Packs the pin and running masks of all lanes and holds the result in an
// output register backed by a skid stage.
// ----------------------------------------------------------------------------
module tmbls_merge #(
  parameter int MOTORS = tmbls_pkg::MOTORS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tmbls_pkg::lane_status_t             status [MOTORS],
  input  wire logic                                load,       // beat accepted
  output logic                                     busy,       // skid stage full
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tmbls_pkg::OUT_DATA_W-1:0]         out_data
);
  import tmbls_pkg::*;

  logic [FIELD_BITS-1:0] in1_mask;
  logic [FIELD_BITS-1:0] in2_mask;
  logic [FIELD_BITS-1:0] run_mask;
  logic [OUT_DATA_W-1:0] result;
  logic [OUT_DATA_W-1:0] skid_data;
  logic                  skid_valid;
  logic                  pop;

  // Pack lane states into the masks; channels beyond the field stay out
  for (genvar i = 0; i < FIELD_BITS; i++) begin : g_pack
    if (i < MOTORS) begin : g_lane
      assign run_mask[i] = status[i].run;
      assign in1_mask[i] = status[i].run & status[i].dir;
      assign in2_mask[i] = status[i].run & ~status[i].dir;
    end else begin : g_none
      assign run_mask[i] = 1'b0;
      assign in1_mask[i] = 1'b0;
      assign in2_mask[i] = 1'b0;
    end
  end

  assign result = OUT_DATA_W'({run_mask, in2_mask, in1_mask});
  assign pop    = out_valid & out_ready;
  assign busy   = skid_valid;

  // Advance the output register and the skid stage; a load never meets a
  // full skid stage because the input is held off while it is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop && skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (load && (!out_valid || pop)) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else if (load) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule : tmbls_merge
`default_nettype wire

>>> rtl/timed_motor_bank_with_limit_stop.sv
`default_nettype none
// A result beat is held in the output register; while it waits, a skid stage keeps
// the input open. Throughput: one beat per cycle while the skid stage is empty;
// every lane updates its 32-bit countdown in the same cycle.
// Reset (rst, synchronous): all countdowns and directions clear, switch levels
// read as released, and no result is pending.
// ----------------------------------------------------------------------------
// timed_motor_bank_with_limit_stop: bank of timed H-bridge channels
// One lane per motor runs its countdown and limit-switch stop; the merge stage
// forms the in1, in2 and running masks after every beat.
// ----------------------------------------------------------------------------
module timed_motor_bank_with_limit_stop #(
  parameter int MOTORS = tmbls_pkg::MOTORS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: switch_levels[13:0], motor_index[17:14], run_ticks[49:18],
  //        reverse_dir[50], zero fill
  input  wire logic [tmbls_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: cmd[0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: in1_levels[13:0], in2_levels[27:14], running_mask[41:28], zero fill
  output logic [tmbls_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import tmbls_pkg::*;

  logic                  accept;
  logic                  busy;
  lane_cmd_t             cmd;
  logic [FIELD_BITS-1:0] sw_levels;
  logic [IDX_W-1:0]      motor_index;
  lane_status_t          status [MOTORS];

  assign s_axis_tready = ~busy;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // Decode the beat for all lanes
  assign sw_levels   = s_axis_tdata[SW_LSB +: FIELD_BITS];
  assign motor_index = s_axis_tdata[IDX_LSB +: IDX_W];
  assign cmd.tick    = accept & (cmd_t'(s_axis_tuser) == CMD_TICK);
  assign cmd.start   = accept & (cmd_t'(s_axis_tuser) == CMD_START);
  assign cmd.dir     = s_axis_tdata[REV_LSB];
  assign cmd.ticks   = s_axis_tdata[TICKS_LSB +: COUNT_W];

  // One lane per channel; channels without a switch bit read released
  for (genvar i = 0; i < MOTORS; i++) begin : g_lane
    logic sel;
    logic sw;
    assign sel = (32'(motor_index) == 32'(i));
    if (i < FIELD_BITS) begin : g_sw
      assign sw = sw_levels[i];
    end else begin : g_nosw
      assign sw = 1'b1;
    end
    tmbls_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel),
      .sw_level (sw),
      .status   (status[i])
    );
  end

  // Merge lane states into the result beat
  tmbls_merge #(
    .MOTORS (MOTORS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .load      (accept),
    .busy      (busy),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule : timed_motor_bank_with_limit_stop
`default_nettype wire

>>> dv/timed_motor_bank_with_limit_stop_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timed_motor_bank_with_limit_stop_tb: self-checking bench for the motor bank
// Drives tick and start beats with bursty valid and a stalling receiver,
// tracks each channel's countdown, direction and last switch level, and
// checks every result beat's pin and running masks in order.
// ----------------------------------------------------------------------------
module timed_motor_bank_with_limit_stop_tb;
  import tmbls_pkg::*;

  localparam int NCH         = MOTORS_DEFAULT;
  localparam int RAND_ITEMS  = 400;
  localparam int DRAIN_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    cmd_t                  cmd;
    logic [FIELD_BITS-1:0] sw;
    logic [IDX_W-1:0]      idx;
    logic [COUNT_W-1:0]    ticks;
    logic                  rev;
    bit                    wait_idle;  // hold until every result is back
  } motor_cmd_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] in1;
    logic [FIELD_BITS-1:0] in2;
    logic [FIELD_BITS-1:0] run;
  } pin_state_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // tdata: switch_levels, motor_index, run_ticks, reverse_dir, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // tuser: cmd
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // tdata: in1_levels, in2_levels, running_mask, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  timed_motor_bank_with_limit_stop #(.MOTORS(NCH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Channel state mirror
  logic [COUNT_W-1:0] chan_count [NCH];
  logic               chan_last_sw [NCH];
  logic               chan_dir [NCH];

  motor_cmd_t cmd_q [$];
  pin_state_t pin_q [$];

  int  err_cnt      = 0;
  int  beats_in     = 0;
  int  results_seen = 0;
  int  start_beats  = 0;
  int  tick_beats   = 0;
  int  starts_drop  = 0;
  int  edge_stops   = 0;
  int  count_stops  = 0;
  bit  beat_taken   = 0;
  int  burst_left   = 0;
  int  gap_left     = 0;
  int  rx_hold_left = 0;
  int  next_hold_at = 120;
  int  holds_done   = 0;
  int  rx_mode      = 0;
  int  rx_phase     = 0;
  pin_state_t pred, want, got;
  motor_cmd_t nxt;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Advance the channel mirror by one beat and form the resulting pin masks
  task automatic step_bank(input cmd_t cmd, input logic [FIELD_BITS-1:0] sw,
                           input logic [IDX_W-1:0] idx, input logic [COUNT_W-1:0] ticks,
                           input logic rev, output pin_state_t res);
    int ch;
    if (cmd == CMD_TICK) begin
      tick_beats++;
      for (ch = 0; ch < NCH; ch++) begin
        if (!sw[ch] && chan_last_sw[ch] && chan_count[ch] != '0) begin
          chan_count[ch] = '0;
          edge_stops++;
        end else if (chan_count[ch] == 1) begin
          chan_count[ch] = '0;
          count_stops++;
        end else if (chan_count[ch] != '0) begin
          chan_count[ch] = chan_count[ch] - 1;
        end
        chan_last_sw[ch] = sw[ch];
      end
    end else begin
      start_beats++;
      if (idx >= NCH || ticks == '0) begin
        starts_drop++;
      end else begin
        chan_count[idx] = ticks;
        chan_dir[idx]   = rev;
      end
    end
    res = '0;
    for (ch = 0; ch < NCH; ch++) begin
      if (chan_count[ch] != '0) begin
        res.run[ch] = 1'b1;
        if (chan_dir[ch]) res.in1[ch] = 1'b1;
        else res.in2[ch] = 1'b1;
      end
    end
  endtask

  task automatic add_cmd(input cmd_t cmd, input logic [FIELD_BITS-1:0] sw,
                         input logic [IDX_W-1:0] idx, input logic [COUNT_W-1:0] ticks,
                         input logic rev, input bit wait_idle = 0);
    motor_cmd_t c;
    c.cmd = cmd; c.sw = sw; c.idx = idx; c.ticks = ticks; c.rev = rev;
    c.wait_idle = wait_idle;
    cmd_q.push_back(c);
  endtask

  // Monitor: predict on every accepted input beat, check every result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_bank(cmd_t'(s_axis_tuser), s_axis_tdata[SW_LSB +: FIELD_BITS],
                  s_axis_tdata[IDX_LSB +: IDX_W], s_axis_tdata[TICKS_LSB +: COUNT_W],
                  s_axis_tdata[REV_LSB], pred);
        pin_q.push_back(pred);
        beats_in++;
        beat_taken = 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.in1 = m_axis_tdata[0 +: FIELD_BITS];
        got.in2 = m_axis_tdata[FIELD_BITS +: FIELD_BITS];
        got.run = m_axis_tdata[2*FIELD_BITS +: FIELD_BITS];
        results_seen++;
        if (pin_q.size() == 0) begin
          flag_error($sformatf("unexpected result in1=%h in2=%h run=%h",
                               got.in1, got.in2, got.run));
        end else begin
          want = pin_q.pop_front();
          if (got.in1 !== want.in1 || got.in2 !== want.in2 || got.run !== want.run)
            flag_error($sformatf(
              "result %0d: in1 exp %h got %h, in2 exp %h got %h, run exp %h got %h",
              results_seen, want.in1, got.in1, want.in2, got.in2, want.run, got.run));
        end
      end
    end
  end

  // Driver: bursts of beats with random gaps, no gaps while the receiver holds off
  always @(negedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !beat_taken) begin
        // hold the current beat until it is taken
      end else begin
        beat_taken = 0;
        if (gap_left > 0 && rx_hold_left == 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].wait_idle && pin_q.size() > 0)) begin
          nxt = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.cmd;
          s_axis_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, nxt.rev, nxt.ticks, nxt.idx, nxt.sw};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(0, 12);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (results_seen >= next_hold_at) begin
        rx_hold_left = HOLD_CYCLES;
        next_hold_at += 200;
        holds_done++;
      end
      if (rx_phase == 0) begin
        rx_mode  = $urandom_range(0, 3);
        rx_phase = $urandom_range(20, 80);
      end else begin
        rx_phase--;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= !m_axis_tready;
        endcase
      end
    end
  end

  // Stimulus and end of run
  initial begin
    motor_cmd_t c;
    int i, k, roll, pick, total;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    m_axis_tready = 1'b0;
    for (i = 0; i < NCH; i++) begin
      chan_count[i]   = '0;
      chan_last_sw[i] = 1'b1;
      chan_dir[i]     = 1'b0;
    end

    // Directed: idle tick with junk start fields, stop at count one, max count,
    // out-of-range index, zero duration, stop on switch edge, restart while
    // pressed and while running, edges on stopped channels
    add_cmd(CMD_TICK,  14'h3FFF, 4'hF, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CMD_START, 14'h0000, 4'd0, 32'd1, 1'b0);
    add_cmd(CMD_TICK,  14'h3FFF, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_START, 14'h3FFF, 4'd13, 32'hFFFF_FFFF, 1'b1);
    add_cmd(CMD_START, 14'h1234, 4'd14, 32'd5, 1'b1);
    add_cmd(CMD_START, 14'h0000, 4'd15, 32'd5, 1'b0);
    add_cmd(CMD_START, 14'h3FFF, 4'd2, 32'd0, 1'b1);
    add_cmd(CMD_START, 14'h0000, 4'd3, 32'd3, 1'b1);
    add_cmd(CMD_TICK,  14'h3FF7, 4'd3, 32'd9, 1'b1);
    add_cmd(CMD_TICK,  14'h3FF7, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_START, 14'h0000, 4'd3, 32'd4, 1'b0);
    add_cmd(CMD_TICK,  14'h3FF7, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_TICK,  14'h3FFF, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_START, 14'h0000, 4'd5, 32'd10, 1'b0);
    add_cmd(CMD_TICK,  14'h3FFF, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_START, 14'h2AAA, 4'd5, 32'd2, 1'b1);
    add_cmd(CMD_TICK,  14'h3FFF, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_TICK,  14'h3FFF, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_TICK,  14'h0000, 4'd7, 32'h5555_5555, 1'b0);
    add_cmd(CMD_TICK,  14'h0000, 4'd0, 32'd0, 1'b0);
    add_cmd(CMD_TICK,  14'h3FFF, 4'd0, 32'd0, 1'b0, 1);
    add_cmd(CMD_START, 14'h0000, 4'd7, 32'h8000_0000, 1'b1);
    add_cmd(CMD_START, 14'h0000, 4'd1, 32'd2, 1'b0);
    add_cmd(CMD_TICK,  14'h3FFF, 4'd0, 32'd0, 1'b0);

    // Random: mostly short runs and released switches, some presses and noise
    for (i = 0; i < RAND_ITEMS; i++) begin
      c.wait_idle = (i == 200);
      c.sw    = FIELD_BITS'($urandom);
      c.idx   = IDX_W'($urandom);
      c.ticks = $urandom;
      c.rev   = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        c.cmd = CMD_START;
        if ($urandom_range(0, 15) == 0) c.idx = IDX_W'($urandom_range(NCH, 15));
        else c.idx = IDX_W'($urandom_range(0, NCH-1));
        pick = $urandom_range(0, 9);
        if (pick < 7) c.ticks = $urandom_range(1, 12);
        else if (pick == 7) c.ticks = '0;
        else if (pick == 8) c.ticks = 32'hFFFF_FFFF;
      end else begin
        c.cmd = CMD_TICK;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          c.sw = '1;
        end else if (pick < 9) begin
          c.sw = '1;
          c.sw[$urandom_range(0, NCH-1)] = 1'b0;
          if ($urandom_range(0, 1)) c.sw[$urandom_range(0, NCH-1)] = 1'b0;
        end
      end
      cmd_q.push_back(c);
    end
    total = cmd_q.size();

    // Reset
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all input beats, then for the last results
    while (beats_in < total) @(posedge clk);
    k = 0;
    while (pin_q.size() > 0 && k < DRAIN_LIMIT) begin
      @(posedge clk);
      k++;
    end
    repeat (8) @(posedge clk);
    if (pin_q.size() > 0)
      flag_error($sformatf("%0d expected results never arrived", pin_q.size()));

    $display("Covered %0d start beats (%0d ignored) and %0d tick beats, %0d results checked",
             start_beats, starts_drop, tick_beats, results_seen);
    $display("Channel stops: %0d on a switch edge, %0d on count expiry; %0d receiver hold-offs",
             edge_stops, count_stops, holds_done);
    if (err_cnt == 0) begin
      $display("timed_motor_bank_with_limit_stop test passed");
    end else begin
      $display("Mismatches: %0d", err_cnt);
      $display("timed_motor_bank_with_limit_stop test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timeout: %0d of the input beats taken, %0d results seen", beats_in, results_seen);
    $display("timed_motor_bank_with_limit_stop test failed");
    $finish;
  end

endmodule : timed_motor_bank_with_limit_stop_tb
`default_nettype wire
